// File: src/assert_macros.svh
// Assertion macros used by the blitter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define GBPF_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define GBPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that a condition implies another in the following cycle.
`define GBPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/gbpf_pkg.sv
// Shared constants and types of the glyph blitter.
`timescale 1ns / 1ps
package gbpf_pkg;

  localparam int SCREEN_WIDTH_DEF  = 640;
  localparam int SCREEN_HEIGHT_DEF = 480;
  localparam int GLYPH_ROWS_DEF    = 8;
  localparam int GLYPH_COUNT_DEF   = 256;

  localparam int COORD_W = 11;  // pos_x and pos_y
  localparam int POS_W   = 12;  // a coordinate plus a column or row offset
  localparam int BASE_W  = 22;  // signed row start within the pixel space
  localparam int ADDR_W  = 18;
  localparam int COUNT_W = 8;   // holds up to 31 full rows of 8 pixels
  localparam int PIX_SAT = 127;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_DRAW = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // One pixel slot handed from the sequencer to the read-modify-write stage.
  typedef struct packed {
    logic       valid;
    logic       visible;
    logic       nib_hi;
    logic [2:0] bit_idx;
  } pix_cmd_t;

endpackage

// File: src/gbpf_ram.sv
// Single-port-write, single-port-read byte memory with registered read data.
`timescale 1ns / 1ps
module gbpf_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read at the address being written returns the old byte.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/gbpf_pix_rmw.sv
// Pixel read-modify-write stage with write-to-read forwarding and pixel count.
`timescale 1ns / 1ps
module gbpf_pix_rmw #(
  parameter int FA_W = 17
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear_count,
  input  gbpf_pkg::pix_cmd_t            cmd,
  input  logic [FA_W-1:0]               cmd_addr,
  input  logic [3:0]                    fg,
  input  logic [3:0]                    bg,
  input  logic [7:0]                    rd_data,
  input  logic [7:0]                    glyph_row,
  output logic                          wr_en,
  output logic [FA_W-1:0]               wr_addr,
  output logic [7:0]                    wr_data,
  output logic [gbpf_pkg::COUNT_W-1:0]  count
);
  import gbpf_pkg::*;

  pix_cmd_t        s1_cmd;
  logic [FA_W-1:0] s1_addr;
  logic            fwd_valid;
  logic [FA_W-1:0] fwd_addr;
  logic [7:0]      fwd_data;
  logic [7:0]      base_byte;
  logic            pix_bit;
  logic [3:0]      colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_cmd    <= '0;
      fwd_valid <= 1'b0;
      count     <= '0;
    end else begin
      s1_cmd    <= cmd;
      fwd_valid <= wr_en;
      if (clear_count) begin
        count <= '0;
      end else if (wr_en) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_addr  <= cmd_addr;
    fwd_addr <= wr_addr;
    fwd_data <= wr_data;
  end

  // The read for this pixel was issued while the previous pixel was being
  // written, so a byte written in the last cycle replaces the memory data.
  assign base_byte = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : rd_data;
  assign pix_bit   = glyph_row[s1_cmd.bit_idx];
  assign colour    = pix_bit ? fg : bg;
  assign wr_en     = s1_cmd.valid && s1_cmd.visible && (pix_bit || fg != bg);
  assign wr_addr   = s1_addr;
  assign wr_data   = s1_cmd.nib_hi ? {colour, base_byte[3:0]} : {base_byte[7:4], colour};

endmodule

// File: src/glyph_blit_packed_framebuffer.sv
// Top level of the character blitter over a packed 4-bit framebuffer.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_stall   mode pos_x pos_y char_code fg_color bg_color
//                                   address load_byte
//   output    out_valid / out_stall read_byte pixels_written
//
// A draw steps one pixel slot a cycle through the single framebuffer memory,
// then a drain state and a finishing state that hands over the result. A read
// passes read-wait and finishing; a glyph load or mode three, finishing only.
// After reset a clearing pass writes zero to every framebuffer byte, one a cycle,
// with in_stall high throughout.
// One word is worked on at a time; a new word is taken while the previous
// result still waits on out_stall, but its own result waits for the register.
`timescale 1ns / 1ps
module glyph_blit_packed_framebuffer #(
  parameter int SCREEN_WIDTH  = gbpf_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = gbpf_pkg::SCREEN_HEIGHT_DEF,
  parameter int GLYPH_ROWS    = gbpf_pkg::GLYPH_ROWS_DEF,
  parameter int GLYPH_COUNT   = gbpf_pkg::GLYPH_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          mode,
  input  logic signed [gbpf_pkg::COORD_W-1:0] pos_x,
  input  logic signed [gbpf_pkg::COORD_W-1:0] pos_y,
  input  logic [7:0]                          char_code,
  input  logic [3:0]                          fg_color,
  input  logic [3:0]                          bg_color,
  input  logic [gbpf_pkg::ADDR_W-1:0]         address,
  input  logic [7:0]                          load_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          read_byte,
  output logic [6:0]                          pixels_written
);
  import gbpf_pkg::*;
  `include "assert_macros.svh"

  localparam int FRAME_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT + 1) / 2;
  localparam int FA_W        = $clog2(FRAME_BYTES);
  localparam int AX_W        = (FA_W > ADDR_W) ? FA_W : ADDR_W;
  localparam int GLYPH_BYTES = GLYPH_COUNT * GLYPH_ROWS;
  localparam int GA_W        = (GLYPH_BYTES > 1) ? $clog2(GLYPH_BYTES) : 1;
  localparam int RW          = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_DRAIN,
    ST_RDWAIT,
    ST_FINISH
  } state_t;

  state_t                    state;
  logic [FA_W-1:0]           clr_addr;
  logic signed [COORD_W-1:0] x0;
  logic signed [POS_W-1:0]   cur_row;
  logic signed [BASE_W-1:0]  row_base;
  logic [GA_W-1:0]           g_ptr;
  logic [2:0]                col_idx;
  logic [RW-1:0]             row_idx;
  logic [3:0]                fg_q;
  logic [3:0]                bg_q;
  logic                      is_draw;
  logic                      rd_ok_q;
  logic [7:0]                res_byte;

  logic                      in_accept;
  logic [7:0]                code_wrap [256];
  logic signed [POS_W-1:0]   cur_col;
  logic                      visible;
  logic signed [BASE_W-1:0]  pix_pos;
  logic [AX_W-1:0]           addr_ext;
  logic                      fb_rd_ok;
  logic                      gl_wr_ok;
  logic [6:0]                sat_count;

  logic                      fm_wr_en;
  logic [FA_W-1:0]           fm_wr_addr;
  logic [7:0]                fm_wr_data;
  logic                      fm_rd_en;
  logic [FA_W-1:0]           fm_rd_addr;
  logic [7:0]                fm_rd_data;
  logic                      gm_wr_en;
  logic                      gm_rd_en;
  logic [7:0]                gm_rd_data;

  pix_cmd_t                  pix_cmd;
  logic                      rmw_wr_en;
  logic [FA_W-1:0]           rmw_wr_addr;
  logic [7:0]                rmw_wr_data;
  logic [COUNT_W-1:0]        pix_count;

  // Character codes wrap modulo the glyph count; the table is fixed at build.
  for (genvar i = 0; i < 256; i++) begin : g_wrap
    assign code_wrap[i] = 8'(i % GLYPH_COUNT);
  end

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign addr_ext = AX_W'(address);
  assign fb_rd_ok = 32'(address) < FRAME_BYTES;
  assign gl_wr_ok = 32'(address) < GLYPH_BYTES;

  // Pixel position of the current slot; only meaningful when it is on screen.
  assign cur_col = POS_W'(x0) + POS_W'($signed({1'b0, col_idx}));
  assign visible = !cur_col[POS_W-1] && (cur_col < POS_W'(SCREEN_WIDTH)) &&
                   !cur_row[POS_W-1] && (cur_row < POS_W'(SCREEN_HEIGHT));
  assign pix_pos = row_base + BASE_W'(cur_col);

  assign pix_cmd.valid   = (state == ST_DRAW);
  assign pix_cmd.visible = visible;
  assign pix_cmd.nib_hi  = pix_pos[0];
  assign pix_cmd.bit_idx = col_idx;

  assign fm_rd_en   = (state == ST_DRAW) || (in_accept && mode == MODE_READ);
  assign fm_rd_addr = (state == ST_DRAW) ? pix_pos[FA_W:1] : addr_ext[FA_W-1:0];
  assign fm_wr_en   = (state == ST_CLEAR) ? 1'b1 : rmw_wr_en;
  assign fm_wr_addr = (state == ST_CLEAR) ? clr_addr : rmw_wr_addr;
  assign fm_wr_data = (state == ST_CLEAR) ? 8'h00 : rmw_wr_data;

  assign gm_wr_en = in_accept && mode == MODE_LOAD && gl_wr_ok;
  assign gm_rd_en = (state == ST_DRAW) && (col_idx == 3'd0);

  assign sat_count = (pix_count > COUNT_W'(PIX_SAT)) ? 7'(PIX_SAT) : pix_count[6:0];

  gbpf_ram #(
    .DEPTH (FRAME_BYTES),
    .AW    (FA_W)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (fm_wr_en),
    .wr_addr (fm_wr_addr),
    .wr_data (fm_wr_data),
    .rd_en   (fm_rd_en),
    .rd_addr (fm_rd_addr),
    .rd_data (fm_rd_data)
  );

  gbpf_ram #(
    .DEPTH (GLYPH_BYTES),
    .AW    (GA_W)
  ) u_glyph_ram (
    .clk     (clk),
    .wr_en   (gm_wr_en),
    .wr_addr (address[GA_W-1:0]),
    .wr_data (load_byte),
    .rd_en   (gm_rd_en),
    .rd_addr (g_ptr),
    .rd_data (gm_rd_data)
  );

  gbpf_pix_rmw #(
    .FA_W (FA_W)
  ) u_pix_rmw (
    .clk         (clk),
    .rst         (rst),
    .clear_count (in_accept),
    .cmd         (pix_cmd),
    .cmd_addr    (pix_pos[FA_W:1]),
    .fg          (fg_q),
    .bg          (bg_q),
    .rd_data     (fm_rd_data),
    .glyph_row   (gm_rd_data),
    .wr_en       (rmw_wr_en),
    .wr_addr     (rmw_wr_addr),
    .wr_data     (rmw_wr_data),
    .count       (pix_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // In the finishing state the result register is reloaded instead.
      if (out_valid && !out_stall && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == FA_W'(FRAME_BYTES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            fg_q     <= fg_color;
            bg_q     <= bg_color;
            x0       <= pos_x;
            cur_row  <= POS_W'(pos_y);
            row_base <= BASE_W'(pos_y) * BASE_W'(SCREEN_WIDTH);
            g_ptr    <= GA_W'(32'(code_wrap[char_code]) * GLYPH_ROWS);
            col_idx  <= '0;
            row_idx  <= '0;
            res_byte <= 8'h00;
            is_draw  <= (mode == MODE_DRAW);
            rd_ok_q  <= fb_rd_ok;
            case (mode)
              MODE_DRAW: state <= ST_DRAW;
              MODE_READ: state <= ST_RDWAIT;
              default:   state <= ST_FINISH;
            endcase
          end
        end
        ST_DRAW: begin
          col_idx <= col_idx + 1'b1;
          if (col_idx == 3'd7) begin
            row_idx  <= row_idx + 1'b1;
            cur_row  <= cur_row + 1'b1;
            row_base <= row_base + BASE_W'(SCREEN_WIDTH);
            g_ptr    <= g_ptr + 1'b1;
            if (row_idx == RW'(GLYPH_ROWS - 1)) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_RDWAIT: begin
          res_byte <= rd_ok_q ? fm_rd_data : 8'h00;
          state    <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            read_byte      <= res_byte;
            pixels_written <= is_draw ? sat_count : 7'd0;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `GBPF_ASSERT(a_idle_no_write, !(state == ST_IDLE && fm_wr_en), "frame write while idle")
  `GBPF_ASSERT(a_glyph_port_excl, !(gm_wr_en && gm_rd_en), "glyph load during a draw")
  `GBPF_ASSERT(a_count_bound, pix_count <= COUNT_W'(8 * GLYPH_ROWS), "pixel count overrun")
  `GBPF_ASSERT_IMP(a_out_from_finish, $rose(out_valid), $past(state) == ST_FINISH, "stray result")
  `GBPF_ASSERT_NXT(a_draw_start, in_accept && mode == MODE_DRAW, state == ST_DRAW, "draw not started")

endmodule
